@@ src/trs_pkg.sv @@
// Package with shared types and constants for the totient range sum block.
`timescale 1ns / 1ps

package trs_pkg;

    // Fixed field widths of the stream beats
    localparam int unsigned BOUND_BITS = 16;
    localparam int unsigned TOTAL_BITS = 32;
    localparam int unsigned IN_DATA_BITS = 2 * BOUND_BITS;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_N,
        ST_DIV_WAIT,
        ST_ACCUM,
        ST_DONE
    } state_t;

    // What the running division is for
    typedef enum logic [1:0] {
        DIV_TRIAL,
        DIV_STRIP,
        DIV_REDUCE,
        DIV_FINAL
    } div_role_t;

endpackage

@@ src/trs_div.sv @@
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module trs_div #(
    parameter int unsigned W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     quo_next;
    logic [W-1:0]     div_reg;
    logic [W-1:0]     div_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    // One shift-subtract step
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    // Load on start, step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/totient_range_sum.sv @@
// Top level: sum of Euler's totient over an inclusive range of values.
// Work: each value n runs d(n) divisions on the divider, where d(n) counts:
// one trial per candidate up to the first past the cofactor's square root, exponent plus one
// per prime factor, one for a leftover prime; 0 and 1 take no divisions.
// Throughput: one range at a time; the single shared divider sets the rate.
// Reset: asynchronous active-low rst_n clears the sequencer and the output valid.
`timescale 1ns / 1ps

module totient_range_sum #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [trs_pkg::IN_DATA_BITS-1:0]   s_tdata,  // range_low, range_high
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [trs_pkg::TOTAL_BITS-1:0]     m_tdata   // totient_total
);

    import trs_pkg::*;

    localparam int unsigned W = VALUE_BITS;

    state_t                state_reg;
    state_t                state_next;
    div_role_t             role_reg;
    div_role_t             role_next;
    logic [W-1:0]          n_reg;
    logic [W-1:0]          n_next;
    logic [W-1:0]          high_reg;
    logic [W-1:0]          high_next;
    logic [W-1:0]          rest_reg;
    logic [W-1:0]          rest_next;
    logic [W-1:0]          res_reg;
    logic [W-1:0]          res_next;
    logic [W-1:0]          p_reg;
    logic [W-1:0]          p_next;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [TOTAL_BITS-1:0] out_data_reg;
    logic [TOTAL_BITS-1:0] out_data_next;

    logic                  div_start;
    logic [W-1:0]          div_dividend;
    logic [W-1:0]          div_divisor;
    logic                  div_done;
    logic [W-1:0]          div_quo;
    logic [W-1:0]          div_rem;
    logic [W-1:0]          low_in;
    logic [W-1:0]          high_in;
    logic                  out_free;

    // Mask or extend the bounds to the value width
    assign low_in   = W'(s_tdata[BOUND_BITS-1:0]);
    assign high_in  = W'(s_tdata[IN_DATA_BITS-1:BOUND_BITS]);
    assign out_free = !out_valid_reg || m_tready;

    trs_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (low_in > high_in) ? ST_DONE : ST_START_N;
                end
            end
            ST_START_N:
            begin
                state_next = (n_reg < W'(2)) ? ST_ACCUM : ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (role_reg == DIV_FINAL)
                    begin
                        state_next = ST_ACCUM;
                    end
                    else if (role_reg == DIV_TRIAL && p_reg > div_quo && rest_reg <= W'(1))
                    begin
                        state_next = ST_ACCUM;
                    end
                end
            end
            ST_ACCUM:
            begin
                state_next = (n_reg == high_reg) ? ST_DONE : ST_START_N;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and divider control
    always_comb
    begin
        role_next      = role_reg;
        n_next         = n_reg;
        high_next      = high_reg;
        rest_next      = rest_reg;
        res_next       = res_reg;
        p_next         = p_reg;
        total_next     = total_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        div_dividend   = rest_reg;
        div_divisor    = p_reg;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    n_next     = low_in;
                    high_next  = high_in;
                    total_next = '0;
                end
            end
            ST_START_N:
            begin
                if (n_reg < W'(2))
                begin
                    res_next = '0;
                end
                else
                begin
                    rest_next    = n_reg;
                    res_next     = n_reg;
                    p_next       = W'(2);
                    role_next    = DIV_TRIAL;
                    div_start    = 1'b1;
                    div_dividend = n_reg;
                    div_divisor  = W'(2);
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (role_reg)
                        DIV_TRIAL:
                        begin
                            if (p_reg > div_quo)
                            begin
                                // p squared exceeds the cofactor: at most one prime is left
                                if (rest_reg > W'(1))
                                begin
                                    role_next    = DIV_FINAL;
                                    div_start    = 1'b1;
                                    div_dividend = res_reg;
                                    div_divisor  = rest_reg;
                                end
                            end
                            else if (div_rem == '0)
                            begin
                                rest_next    = div_quo;
                                role_next    = DIV_STRIP;
                                div_start    = 1'b1;
                                div_dividend = div_quo;
                                div_divisor  = p_reg;
                            end
                            else
                            begin
                                p_next       = p_reg + W'(1);
                                div_start    = 1'b1;
                                div_dividend = rest_reg;
                                div_divisor  = p_reg + W'(1);
                            end
                        end
                        DIV_STRIP:
                        begin
                            if (div_rem == '0)
                            begin
                                rest_next    = div_quo;
                                div_start    = 1'b1;
                                div_dividend = div_quo;
                                div_divisor  = p_reg;
                            end
                            else
                            begin
                                role_next    = DIV_REDUCE;
                                div_start    = 1'b1;
                                div_dividend = res_reg;
                                div_divisor  = p_reg;
                            end
                        end
                        DIV_REDUCE:
                        begin
                            res_next     = res_reg - div_quo;
                            p_next       = p_reg + W'(1);
                            role_next    = DIV_TRIAL;
                            div_start    = 1'b1;
                            div_dividend = rest_reg;
                            div_divisor  = p_reg + W'(1);
                        end
                        DIV_FINAL:
                        begin
                            res_next = res_reg - div_quo;
                        end
                        default:
                        begin
                            role_next = DIV_TRIAL;
                        end
                    endcase
                end
            end
            ST_ACCUM:
            begin
                total_next = total_reg + TOTAL_BITS'(res_reg);
                if (n_reg != high_reg)
                begin
                    n_next = n_reg + W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = total_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            role_reg      <= DIV_TRIAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            role_reg      <= role_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        high_reg     <= high_next;
        rest_reg     <= rest_next;
        res_reg      <= res_next;
        p_reg        <= p_next;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The divider only reports while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait state");

    // Trial divisors never drop below two
    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_WAIT |-> p_reg >= W'(2))
        else $error("trial divisor below two");

    // A count is below its value, or zero for zero and one
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACCUM |-> (res_reg < n_reg) || (res_reg == '0))
        else $error("coprime count out of range");

    // An accepted beat starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted beat left the sequencer idle");

endmodule
